// ===== rtl/core/kar_pkg.sv =====
// Package for the accelerating key auto-repeat block.
// Holds shared widths, register indexes, event codes and the structs that pass
// configuration and per-key results between the modules. Depends on nothing.
`timescale 1ns / 1ps

package kar_pkg;

    // Fixed field widths.
    localparam int KEY_SLOTS    = 8;
    localparam int KEY_IDX_W    = 3;
    localparam int EVENT_W      = 2;
    localparam int COUNT_W      = 16;
    localparam int PRESCALE_W   = 6;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    // Default parameter values.
    localparam int KAR_NUM_KEYS       = 8;
    localparam int KAR_RELEASE_PERIOD = 50;

    // Repeat cadences and their residue counter widths.
    localparam int SLOW_PERIOD = 50;
    localparam int FAST_PERIOD = 5;
    localparam int SLOW_RES_W  = 6;
    localparam int FAST_RES_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_REPEAT_MASK = 3'd0;
    localparam logic [2:0] REG_SLOW_START  = 3'd1;
    localparam logic [2:0] REG_FAST_START  = 3'd2;
    localparam logic [2:0] REG_CONT_START  = 3'd3;
    localparam logic [2:0] REG_IDLE_LIMIT  = 3'd4;

    // Event codes.
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_PRESS  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_REPEAT = 2'd2;

    typedef struct packed {
        logic [KEY_SLOTS-1:0] repeat_key_mask;
        logic [COUNT_W-1:0]   slow_start;
        logic [COUNT_W-1:0]   fast_start;
        logic [COUNT_W-1:0]   continuous_start;
        logic [COUNT_W-1:0]   idle_limit;
    } kar_cfg_t;

    // One key's result as it travels down the chain.
    typedef struct packed {
        logic [EVENT_W-1:0] key_event;
        logic               activity;
    } kar_slot_t;

endpackage

// ===== rtl/core/kar_cfg.sv =====
// Configuration register file of the key auto-repeat block, APB-style access.
// Depends on kar_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module kar_cfg
    import kar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output kar_cfg_t              cfg
);

    kar_cfg_t   cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_key_mask  <= KEY_SLOTS'(48);
            cfg_reg.slow_start       <= COUNT_W'(1000);
            cfg_reg.fast_start       <= COUNT_W'(3000);
            cfg_reg.continuous_start <= COUNT_W'(6000);
            cfg_reg.idle_limit       <= COUNT_W'(1000);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_REPEAT_MASK: cfg_reg.repeat_key_mask  <= pwdata[KEY_SLOTS-1:0];
                REG_SLOW_START:  cfg_reg.slow_start       <= pwdata[COUNT_W-1:0];
                REG_FAST_START:  cfg_reg.fast_start       <= pwdata[COUNT_W-1:0];
                REG_CONT_START:  cfg_reg.continuous_start <= pwdata[COUNT_W-1:0];
                REG_IDLE_LIMIT:  cfg_reg.idle_limit       <= pwdata[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_REPEAT_MASK: prdata = APB_DATA_W'(cfg_reg.repeat_key_mask);
            REG_SLOW_START:  prdata = APB_DATA_W'(cfg_reg.slow_start);
            REG_FAST_START:  prdata = APB_DATA_W'(cfg_reg.fast_start);
            REG_CONT_START:  prdata = APB_DATA_W'(cfg_reg.continuous_start);
            REG_IDLE_LIMIT:  prdata = APB_DATA_W'(cfg_reg.idle_limit);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/kar_cell.sv =====
// One key cell: the key's saturating hold counter with its repeat residues,
// and one slot of the result chain. Depends on kar_pkg.
`timescale 1ns / 1ps

module kar_cell
    import kar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  kar_cfg_t  cfg,
    input  logic      load,
    input  logic      shift,
    input  logic      held,
    input  logic      repeatable,
    input  logic      clear_tick,
    input  kar_slot_t slot_in,
    output kar_slot_t slot_out
);

    logic [COUNT_W-1:0]    count_reg,  count_next;
    logic [SLOW_RES_W-1:0] slow_res_reg, slow_res_next;
    logic [FAST_RES_W-1:0] fast_res_reg, fast_res_next;
    kar_slot_t             slot_reg,   slot_next;
    logic                  at_max;
    logic                  rep;
    logic [COUNT_W-1:0]    count_inc;

    // The residues track the count modulo the two cadences, so the repeat
    // test needs no divider: the count only ever steps by one or clears.
    assign at_max    = (count_reg == COUNT_MAX);
    assign count_inc = at_max ? count_reg : count_reg + COUNT_W'(1);
    assign rep = ((count_reg > cfg.slow_start) && (slow_res_reg == '0)) ||
                 ((count_reg > cfg.fast_start) && (fast_res_reg == '0)) ||
                 (count_reg > cfg.continuous_start);

    always_comb
    begin
        count_next    = count_reg;
        slow_res_next = slow_res_reg;
        fast_res_next = fast_res_reg;
        slot_next.key_event = EV_NONE;
        slot_next.activity  = 1'b0;
        if (held)
        begin
            if (count_reg == '0)
                slot_next.key_event = EV_PRESS;
            else if (repeatable && rep)
                slot_next.key_event = EV_REPEAT;
            count_next = count_inc;
            if (!at_max)
            begin
                slow_res_next = (slow_res_reg == SLOW_RES_W'(SLOW_PERIOD - 1)) ?
                                '0 : slow_res_reg + SLOW_RES_W'(1);
                fast_res_next = (fast_res_reg == FAST_RES_W'(FAST_PERIOD - 1)) ?
                                '0 : fast_res_reg + FAST_RES_W'(1);
            end
            slot_next.activity = (count_inc < cfg.idle_limit);
        end
        else if (clear_tick)
        begin
            count_next    = '0;
            slow_res_next = '0;
            fast_res_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            slow_res_reg <= '0;
            fast_res_reg <= '0;
        end
        else if (load)
        begin
            count_reg    <= count_next;
            slow_res_reg <= slow_res_next;
            fast_res_reg <= fast_res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= slot_next;
        else if (shift)
            slot_reg <= slot_in;
    end

    assign slot_out = slot_reg;

endmodule

// ===== rtl/core/key_autorepeat_accelerating.sv =====
// Accelerating key auto-repeat: top level with the row of key cells.
// Path: a tick's results are registered in the key cells on acceptance, then pass through the output register.
// Throughput: one result per cycle while out_stall is low, set by the single result chain
// that drains through one output register; a new tick is taken as the last result leaves.
// Reset: hold counters and release prescaler clear, registers take their defaults.
// Depends on kar_pkg, kar_cfg and kar_cell.
`timescale 1ns / 1ps

module key_autorepeat_accelerating
    import kar_pkg::*;
#(
    parameter int NUM_KEYS       = KAR_NUM_KEYS,
    parameter int RELEASE_PERIOD = KAR_RELEASE_PERIOD
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Poll tick request channel.
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [KEY_SLOTS-1:0]  keys_held,
    // Per-key result channel.
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KEY_IDX_W-1:0]  key_index,
    output logic [EVENT_W-1:0]    key_event,
    output logic                  activity,
    output logic                  last_of_tick,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Only the first eight keys have state; a larger NUM_KEYS still serves eight.
    localparam int KEYS   = (NUM_KEYS > KEY_SLOTS) ? KEY_SLOTS :
                            ((NUM_KEYS < 1) ? 1 : NUM_KEYS);
    localparam int PERIOD = (RELEASE_PERIOD < 1) ? 1 :
                            ((RELEASE_PERIOD > 63) ? 63 : RELEASE_PERIOD);
    localparam int REM_W  = $clog2(KEYS + 1);
    localparam int IDX_W  = (KEYS > 1) ? $clog2(KEYS) : 1;

    kar_cfg_t cfg;

    kar_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Chain control. remain_reg counts the results still waiting in the
    // cells; idx_reg is the key number of the result at the head of the chain.
    logic [REM_W-1:0]      remain_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [PRESCALE_W-1:0] prescale_reg;
    logic                  out_valid_reg;
    logic [KEY_IDX_W-1:0]  key_index_reg;
    logic [EVENT_W-1:0]    key_event_reg;
    logic                  activity_reg;
    logic                  last_reg;

    logic                  out_free;
    logic                  pop;
    logic                  accept;
    logic                  clear_tick;
    logic [PRESCALE_W:0]   prescale_inc;

    // The output register frees up when it is empty or being taken. A new
    // tick is taken once the chain is empty, or as its last result leaves.
    assign out_free   = !out_valid_reg || !out_stall;
    assign pop        = (remain_reg != '0) && out_free;
    assign in_stall   = !((remain_reg == '0) ||
                          ((remain_reg == REM_W'(1)) && out_free));
    assign accept     = in_valid && !in_stall;
    assign clear_tick = (prescale_reg == '0);

    // Row of key cells. Every cell evaluates its own key when a tick is
    // accepted and then hands its result toward cell zero each cycle the
    // head result moves into the output register.
    kar_slot_t chain [KEYS+1];
    assign chain[KEYS] = '0;

    for (genvar k = 0; k < KEYS; k++)
    begin : g_cell
        kar_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg        (cfg),
            .load       (accept),
            .shift      (pop),
            .held       (keys_held[k]),
            .repeatable (cfg.repeat_key_mask[k]),
            .clear_tick (clear_tick),
            .slot_in    (chain[k+1]),
            .slot_out   (chain[k])
        );
    end

    assign prescale_inc = {1'b0, prescale_reg} + (PRESCALE_W+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg    <= '0;
            idx_reg       <= '0;
            prescale_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                remain_reg <= REM_W'(KEYS);
            else if (pop)
                remain_reg <= remain_reg - REM_W'(1);

            if (accept)
                idx_reg <= '0;
            else if (pop)
                idx_reg <= idx_reg + IDX_W'(1);

            // The release prescaler advances once per tick and wraps at the period.
            if (accept)
                prescale_reg <= (prescale_inc >= (PRESCALE_W+1)'(PERIOD)) ?
                                '0 : prescale_inc[PRESCALE_W-1:0];

            if (pop)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            key_index_reg <= KEY_IDX_W'(idx_reg);
            key_event_reg <= chain[0].key_event;
            activity_reg  <= chain[0].activity;
            last_reg      <= (idx_reg == IDX_W'(KEYS - 1));
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_index    = key_index_reg;
    assign key_event    = key_event_reg;
    assign activity     = activity_reg;
    assign last_of_tick = last_reg;

endmodule
